[rtl/alle_pkg.sv]
package alle_pkg;

    localparam int POOL_DEPTH_DEF = 512;

    localparam int ACT_W    = 3;
    localparam int IDX_W    = 9;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 10;

    localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_AT   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVF     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] read_value;
        logic [SIZE_W-1:0]       list_size;
    } rsp_t;

endpackage

[rtl/array_linked_list_engine_unit.sv]
// one request at a time: the next can be accepted in the same cycle that response valid rises
// insert at head, append to empty: S_FREE, S_FCAP, S_TAKE, S_FIN; delete at 0: S_DRD, S_DEL,
// S_FREED, S_FIN; errors go to S_FIN; positional requests first walk k links from the head in
// S_WALK (one link read per cycle from the link memory), then go on through their own states
// reset clears control state only; the memories are not swept, untouched link entries are
// recognized by a high-water mark and read as their initial chain value
module array_linked_list_engine_unit
    import alle_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int PW = $clog2(POOL_DEPTH + 1);
    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = (PW > IDX_W) ? PW : IDX_W;
    localparam logic [PW-1:0] NULL_PTR = PW'(POOL_DEPTH);

    typedef enum logic [13:0] {
        S_IDLE  = 14'h0001,
        S_WALK  = 14'h0002,
        S_FREE  = 14'h0004,
        S_FCAP  = 14'h0008,
        S_TAKE  = 14'h0010,
        S_LINKP = 14'h0020,
        S_PRD   = 14'h0040,
        S_PCAP  = 14'h0080,
        S_DRD   = 14'h0100,
        S_DEL   = 14'h0200,
        S_FREED = 14'h0400,
        S_VRD   = 14'h0800,
        S_VCAP  = 14'h1000,
        S_FIN   = 14'h2000
    } state_t;

    state_t state_reg, state_next;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] free_reg, free_next;
    logic [PW-1:0] count_reg, count_next;
    logic [PW-1:0] hwm_reg, hwm_next;

    logic [ACT_W-1:0]    op_reg, op_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [PW-1:0]       cur_reg, cur_next;
    logic [CW-1:0]       steps_reg, steps_next;
    logic                fresh_reg, fresh_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [PW-1:0]       d_reg, d_next;
    logic [PW-1:0]       free_nx_reg, free_nx_next;
    logic [PW-1:0]       tk_link_reg, tk_link_next;
    logic                set_head_reg, set_head_next;
    logic                link_p_reg, link_p_next;
    logic                del_mid_reg, del_mid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VAL_W-1:0]    rv_reg, rv_next;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;
    logic rsp_load;

    // node memories
    logic [PW-1:0]    link_mem [POOL_DEPTH];
    logic [VAL_W-1:0] value_mem [POOL_DEPTH];

    logic             link_rd_en, link_we;
    logic [PW-1:0]    link_rd_ptr, link_wa, link_wd;
    logic             val_rd_en, val_we;
    logic [PW-1:0]    val_rd_ptr, val_wa;
    logic [VAL_W-1:0] val_wd;

    logic [PW-1:0]    link_rdata_reg;
    logic             link_virgin_reg;
    logic [PW-1:0]    link_p1_reg;
    logic [VAL_W-1:0] val_rdata_reg;
    logic [PW-1:0]    link_q;

    logic          full;
    logic [CW-1:0] idx_w, cnt_w;
    logic [PW-1:0] cur_w;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa[AW-1:0]] <= link_wd;
        end
        if (link_rd_en)
        begin
            link_rdata_reg <= link_mem[link_rd_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_mem[val_wa[AW-1:0]] <= val_wd;
        end
        if (val_rd_en)
        begin
            val_rdata_reg <= value_mem[val_rd_ptr[AW-1:0]];
        end
    end

    // entries at or above the high-water mark were never written: they still link to i+1
    always_ff @(posedge clk)
    begin
        if (link_rd_en)
        begin
            link_virgin_reg <= (link_rd_ptr >= hwm_reg);
            link_p1_reg     <= link_rd_ptr + 1'b1;
        end
    end

    assign link_q = link_virgin_reg ? link_p1_reg : link_rdata_reg;

    assign full  = (free_reg == NULL_PTR);
    assign idx_w = CW'(req.index);
    assign cnt_w = CW'(count_reg);
    assign cur_w = fresh_reg ? link_q : cur_reg;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        free_next     = free_reg;
        count_next    = count_reg;
        hwm_next      = hwm_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        cur_next      = cur_reg;
        steps_next    = steps_reg;
        fresh_next    = fresh_reg;
        p_next        = p_reg;
        d_next        = d_reg;
        free_nx_next  = free_nx_reg;
        tk_link_next  = tk_link_reg;
        set_head_next = set_head_reg;
        link_p_next   = link_p_reg;
        del_mid_next  = del_mid_reg;
        status_next   = status_reg;
        rv_next       = rv_reg;
        rsp_load      = 1'b0;

        link_rd_en  = 1'b0;
        link_rd_ptr = cur_w;
        link_we     = 1'b0;
        link_wa     = p_reg;
        link_wd     = d_reg;
        val_rd_en   = 1'b0;
        val_rd_ptr  = d_reg;
        val_we      = 1'b0;
        val_wa      = free_reg;
        val_wd      = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next       = req.action;
                    val_next      = req.value;
                    status_next   = ST_OK;
                    rv_next       = '0;
                    cur_next      = head_reg;
                    fresh_next    = 1'b0;
                    set_head_next = 1'b0;
                    link_p_next   = 1'b0;
                    del_mid_next  = 1'b0;
                    tk_link_next  = NULL_PTR;
                    state_next    = S_FIN;
                    case (req.action)
                        ACT_INS_HEAD:
                        begin
                            if (full)
                            begin
                                status_next = ST_OVF;
                            end
                            else
                            begin
                                tk_link_next  = head_reg;
                                set_head_next = 1'b1;
                                state_next    = S_FREE;
                            end
                        end
                        ACT_INS_AT:
                        begin
                            if (full)
                            begin
                                status_next = ST_OVF;
                            end
                            else if (idx_w == '0 || idx_w >= cnt_w)
                            begin
                                status_next = ST_BAD_IDX;
                            end
                            else
                            begin
                                steps_next  = idx_w - 1'b1;
                                link_p_next = 1'b1;
                                state_next  = S_WALK;
                            end
                        end
                        ACT_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_OVF;
                            end
                            else if (count_reg == '0 || head_reg == NULL_PTR)
                            begin
                                set_head_next = 1'b1;
                                state_next    = S_FREE;
                            end
                            else
                            begin
                                steps_next  = cnt_w - 1'b1;
                                link_p_next = 1'b1;
                                state_next  = S_WALK;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (idx_w >= cnt_w)
                            begin
                                status_next = ST_BAD_IDX;
                            end
                            else if (idx_w == '0)
                            begin
                                if (head_reg == NULL_PTR)
                                begin
                                    status_next = ST_BAD_IDX;
                                end
                                else
                                begin
                                    d_next     = head_reg;
                                    state_next = S_DRD;
                                end
                            end
                            else
                            begin
                                steps_next   = idx_w - 1'b1;
                                del_mid_next = 1'b1;
                                state_next   = S_WALK;
                            end
                        end
                        ACT_READ:
                        begin
                            if (idx_w >= cnt_w)
                            begin
                                status_next = ST_BAD_IDX;
                            end
                            else
                            begin
                                steps_next = idx_w;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            // one link per cycle: read data of the last step is the next address
            S_WALK:
            begin
                if (cur_w == NULL_PTR)
                begin
                    status_next = ST_BAD_IDX;
                    state_next  = S_FIN;
                end
                else if (steps_reg == '0)
                begin
                    p_next = cur_w;
                    case (op_reg)
                        ACT_DELETE: state_next = S_PRD;
                        ACT_READ:   state_next = S_VRD;
                        default:    state_next = S_FREE;
                    endcase
                end
                else
                begin
                    link_rd_en  = 1'b1;
                    link_rd_ptr = cur_w;
                    cur_next    = cur_w;
                    steps_next  = steps_reg - 1'b1;
                    fresh_next  = 1'b1;
                end
            end
            S_FREE:
            begin
                link_rd_en  = 1'b1;
                link_rd_ptr = free_reg;
                state_next  = S_FCAP;
            end
            S_FCAP:
            begin
                free_nx_next = link_q;
                if (op_reg == ACT_INS_AT)
                begin
                    link_rd_en  = 1'b1;
                    link_rd_ptr = p_reg;
                end
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                val_we     = 1'b1;
                val_wa     = free_reg;
                val_wd     = val_reg;
                link_we    = 1'b1;
                link_wa    = free_reg;
                link_wd    = (op_reg == ACT_INS_AT) ? link_q : tk_link_reg;
                free_next  = free_nx_reg;
                count_next = count_reg + 1'b1;
                d_next     = free_reg;
                if (free_reg == hwm_reg)
                begin
                    hwm_next = hwm_reg + 1'b1;
                end
                if (set_head_reg)
                begin
                    head_next = free_reg;
                end
                state_next = link_p_reg ? S_LINKP : S_FIN;
            end
            S_LINKP:
            begin
                link_we    = 1'b1;
                link_wa    = p_reg;
                link_wd    = d_reg;
                state_next = S_FIN;
            end
            S_PRD:
            begin
                link_rd_en  = 1'b1;
                link_rd_ptr = p_reg;
                state_next  = S_PCAP;
            end
            S_PCAP:
            begin
                if (link_q == NULL_PTR)
                begin
                    status_next = ST_BAD_IDX;
                    state_next  = S_FIN;
                end
                else
                begin
                    d_next     = link_q;
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                link_rd_en  = 1'b1;
                link_rd_ptr = d_reg;
                val_rd_en   = 1'b1;
                val_rd_ptr  = d_reg;
                state_next  = S_DEL;
            end
            S_DEL:
            begin
                rv_next = val_rdata_reg;
                if (del_mid_reg)
                begin
                    link_we = 1'b1;
                    link_wa = p_reg;
                    link_wd = link_q;
                end
                else
                begin
                    head_next = link_q;
                end
                state_next = S_FREED;
            end
            // freed node goes on top of the free list
            S_FREED:
            begin
                link_we    = 1'b1;
                link_wa    = d_reg;
                link_wd    = free_reg;
                free_next  = d_reg;
                count_next = count_reg - 1'b1;
                state_next = S_FIN;
            end
            S_VRD:
            begin
                val_rd_en  = 1'b1;
                val_rd_ptr = p_reg;
                state_next = S_VCAP;
            end
            S_VCAP:
            begin
                rv_next    = val_rdata_reg;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NULL_PTR;
            free_reg      <= '0;
            count_reg     <= '0;
            hwm_reg       <= '0;
            op_reg        <= ACT_INS_HEAD;
            steps_reg     <= '0;
            fresh_reg     <= 1'b0;
            set_head_reg  <= 1'b0;
            link_p_reg    <= 1'b0;
            del_mid_reg   <= 1'b0;
            status_reg    <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            hwm_reg       <= hwm_next;
            op_reg        <= op_next;
            steps_reg     <= steps_next;
            fresh_reg     <= fresh_next;
            set_head_reg  <= set_head_next;
            link_p_reg    <= link_p_next;
            del_mid_reg   <= del_mid_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        cur_reg     <= cur_next;
        p_reg       <= p_next;
        d_reg       <= d_next;
        free_nx_reg <= free_nx_next;
        tk_link_reg <= tk_link_next;
        rv_reg      <= rv_next;
        if (rsp_load)
        begin
            rsp_reg.status     <= status_reg;
            rsp_reg.read_value <= rv_reg;
            rsp_reg.list_size  <= SIZE_W'(count_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_free_empty_iff_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((free_reg == NULL_PTR) == (count_reg == NULL_PTR)))
        else $error("free list state disagrees with element count");

    a_head_null_iff_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((head_reg == NULL_PTR) == (count_reg == '0)))
        else $error("head pointer disagrees with element count");

    a_count_below_hwm: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= hwm_reg) && (hwm_reg <= NULL_PTR))
        else $error("list holds more nodes than were ever taken");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start work");

endmodule
